// ===== hdl/cfwl_pkg.sv =====
// shared constants, codes and helpers for the coordinate queue
package cfwl_pkg;

    // grid and queue geometry
    localparam int GRID_SIDE   = 16;
    localparam int QUEUE_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // fixed field widths of the request and response
    localparam int ACT_W   = 3;
    localparam int COORD_W = 4;
    localparam int KEY_W   = 2 * COORD_W;
    localparam int OCC_W   = 9;

    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(QUEUE_DEPTH - 1);

    // action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_RESET  = 3'd3,
        ACT_LOOKUP = 3'd4
    } t_action;

    // circular pointer step with wrap at the last entry
    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] nxt;
        nxt = (p == LAST_ADDR) ? '0 : p + ADDR_W'(1);
        return nxt;
    endfunction

endpackage

// ===== hdl/cfwl_if.sv =====
// request and response channel interfaces

// request channel: action and cell coordinates
interface cfwl_req_if;
    logic                          valid;
    logic                          ready;
    logic [cfwl_pkg::ACT_W-1:0]    action;
    logic [cfwl_pkg::COORD_W-1:0]  cell_x;
    logic [cfwl_pkg::COORD_W-1:0]  cell_y;

    modport source (output valid, output action, output cell_x, output cell_y,
                    input ready);
    modport sink   (input valid, input action, input cell_x, input cell_y,
                    output ready);
endinterface

// response channel: head entry, search result and status
interface cfwl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          head_valid;
    logic [cfwl_pkg::COORD_W-1:0]  head_x;
    logic [cfwl_pkg::COORD_W-1:0]  head_y;
    logic                          found;
    logic                          overflow;
    logic                          is_empty;
    logic [cfwl_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output head_valid, output head_x, output head_y,
                    output found, output overflow, output is_empty, output occupancy,
                    input ready);
    modport sink   (input valid, input head_valid, input head_x, input head_y,
                    input found, input overflow, input is_empty, input occupancy,
                    output ready);
endinterface

// ===== hdl/coordinate_fifo_with_lookup.sv =====
// top level: circular queue of grid cells with head peek and membership search
// flow: a taken request runs in S_EXEC, peek then reads the head in S_PEEK, lookup walks
// the entries in S_SCAN and stops early on a hit; all end in S_DONE, which registers the response
// throughput: one request at a time; a lookup walks the live entries through the single
// ram read port, one entry per cycle, so its cost follows the queue occupancy
// reset: synchronous active low; clears pointers, count and control, entry ram is not cleared
module coordinate_fifo_with_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfwl_req_if.sink    i_req,
    cfwl_rsp_if.source  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                              r_state, n_state;
    logic [cfwl_pkg::ACT_W-1:0]          r_action, n_action;
    logic [cfwl_pkg::KEY_W-1:0]          r_key, n_key;
    logic [cfwl_pkg::ADDR_W-1:0]         r_rd_ptr, n_rd_ptr;
    logic [cfwl_pkg::ADDR_W-1:0]         r_wr_ptr, n_wr_ptr;
    logic [cfwl_pkg::CNT_W-1:0]          r_count, n_count;
    logic [cfwl_pkg::ADDR_W-1:0]         r_scan_ptr, n_scan_ptr;
    logic [cfwl_pkg::CNT_W-1:0]          r_scan_left, n_scan_left;
    logic                                r_scan_pend, n_scan_pend;
    logic                                r_found, n_found;
    logic                                r_ovf, n_ovf;
    logic                                r_head_valid, n_head_valid;
    logic [cfwl_pkg::KEY_W-1:0]          r_head_key, n_head_key;
    logic                                r_out_valid, n_out_valid;
    logic                                r_out_head_valid, n_out_head_valid;
    logic [cfwl_pkg::KEY_W-1:0]          r_out_head_key, n_out_head_key;
    logic                                r_out_found, n_out_found;
    logic                                r_out_ovf, n_out_ovf;
    logic                                r_out_empty, n_out_empty;
    logic [cfwl_pkg::OCC_W-1:0]          r_out_occ, n_out_occ;

    logic                                ram_we;
    logic                                ram_re;
    logic [cfwl_pkg::ADDR_W-1:0]         ram_waddr;
    logic [cfwl_pkg::ADDR_W-1:0]         ram_raddr;
    logic [cfwl_pkg::KEY_W-1:0]          ram_rdata;
    logic                                out_free;

    // entry store
    cfwl_ram #(
        .WIDTH (cfwl_pkg::KEY_W),
        .DEPTH (cfwl_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_key),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // next-state and datapath control
    always_comb begin
        n_state          = r_state;
        n_action         = r_action;
        n_key            = r_key;
        n_rd_ptr         = r_rd_ptr;
        n_wr_ptr         = r_wr_ptr;
        n_count          = r_count;
        n_scan_ptr       = r_scan_ptr;
        n_scan_left      = r_scan_left;
        n_scan_pend      = r_scan_pend;
        n_found          = r_found;
        n_ovf            = r_ovf;
        n_head_valid     = r_head_valid;
        n_head_key       = r_head_key;
        n_out_valid      = r_out_valid;
        n_out_head_valid = r_out_head_valid;
        n_out_head_key   = r_out_head_key;
        n_out_found      = r_out_found;
        n_out_ovf        = r_out_ovf;
        n_out_empty      = r_out_empty;
        n_out_occ        = r_out_occ;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_waddr        = r_wr_ptr;
        ram_raddr        = r_rd_ptr;

        // response taken downstream
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action = i_req.action;
                    n_key    = {i_req.cell_y, i_req.cell_x};
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_found      = 1'b0;
                n_ovf        = 1'b0;
                n_head_valid = 1'b0;
                n_head_key   = '0;
                n_state      = S_DONE;
                case (r_action)
                    cfwl_pkg::ACT_PUSH: begin
                        if (r_count == cfwl_pkg::FULL_COUNT) begin
                            n_ovf = 1'b1;
                        end else begin
                            ram_we   = 1'b1;
                            n_wr_ptr = cfwl_pkg::advance(r_wr_ptr);
                            n_count  = r_count + cfwl_pkg::CNT_W'(1);
                        end
                    end
                    cfwl_pkg::ACT_POP: begin
                        if (r_count != '0) begin
                            n_rd_ptr = cfwl_pkg::advance(r_rd_ptr);
                            n_count  = r_count - cfwl_pkg::CNT_W'(1);
                        end
                    end
                    cfwl_pkg::ACT_PEEK: begin
                        if (r_count != '0) begin
                            ram_re  = 1'b1;
                            n_state = S_PEEK;
                        end
                    end
                    cfwl_pkg::ACT_RESET: begin
                        n_rd_ptr = '0;
                        n_wr_ptr = '0;
                        n_count  = '0;
                    end
                    cfwl_pkg::ACT_LOOKUP: begin
                        n_scan_ptr  = r_rd_ptr;
                        n_scan_left = r_count;
                        n_scan_pend = 1'b0;
                        n_state     = S_SCAN;
                    end
                    default: begin
                    end
                endcase
            end
            S_PEEK: begin
                n_head_valid = 1'b1;
                n_head_key   = ram_rdata;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                ram_raddr = r_scan_ptr;
                if (r_scan_pend && (ram_rdata == r_key)) begin
                    n_found     = 1'b1;
                    n_scan_pend = 1'b0;
                    n_state     = S_DONE;
                end else if (r_scan_left == '0) begin
                    n_scan_pend = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    ram_re      = 1'b1;
                    n_scan_ptr  = cfwl_pkg::advance(r_scan_ptr);
                    n_scan_left = r_scan_left - cfwl_pkg::CNT_W'(1);
                    n_scan_pend = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out_head_valid = r_head_valid;
                    n_out_head_key   = r_head_key;
                    n_out_found      = r_found;
                    n_out_ovf        = r_ovf;
                    n_out_empty      = (r_count == '0);
                    n_out_occ        = cfwl_pkg::OCC_W'(r_count);
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_scan_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_count     <= n_count;
            r_scan_pend <= n_scan_pend;
            r_out_valid <= n_out_valid;
        end
        r_action         <= n_action;
        r_key            <= n_key;
        r_scan_ptr       <= n_scan_ptr;
        r_scan_left      <= n_scan_left;
        r_found          <= n_found;
        r_ovf            <= n_ovf;
        r_head_valid     <= n_head_valid;
        r_head_key       <= n_head_key;
        r_out_head_valid <= n_out_head_valid;
        r_out_head_key   <= n_out_head_key;
        r_out_found      <= n_out_found;
        r_out_ovf        <= n_out_ovf;
        r_out_empty      <= n_out_empty;
        r_out_occ        <= n_out_occ;
    end

    // response payload
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.head_valid = r_out_head_valid;
    assign o_rsp.head_x     = r_out_head_key[cfwl_pkg::COORD_W-1:0];
    assign o_rsp.head_y     = r_out_head_key[cfwl_pkg::KEY_W-1:cfwl_pkg::COORD_W];
    assign o_rsp.found      = r_out_found;
    assign o_rsp.overflow   = r_out_ovf;
    assign o_rsp.is_empty   = r_out_empty;
    assign o_rsp.occupancy  = r_out_occ;

    // count never exceeds the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cfwl_pkg::FULL_COUNT)
        else $error("entry count above queue depth");

    // no store write when the queue is full
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count != cfwl_pkg::FULL_COUNT))
        else $error("entry store written while full");

    // a valid head implies a non-empty queue
    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.head_valid) |-> !o_rsp.is_empty)
        else $error("head reported on empty queue");

    // empty flag agrees with occupancy
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.is_empty == (o_rsp.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule

// ===== hdl/cfwl_ram.sv =====
// generic simple dual-port ram with registered read
module cfwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
